@@ hw/rtl/mtw_pkg.sv @@
// Shared types and constants of the MT19937 word generator.
`default_nettype none

package mtw_pkg;

  // Word and table geometry
  localparam int WORD_W       = 32;
  localparam int TABLE_DEPTH  = 624;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int TWIST_OFFSET = 397;

  // Seeding and twist constants
  localparam logic [WORD_W-1:0] INIT_MULT     = 32'd1812433253;
  localparam logic [WORD_W-1:0] SEED_AT_RESET = 32'd5489;
  localparam logic [WORD_W-1:0] TWIST_MATRIX  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS_MASK = 32'h7fff_ffff;

  // Tempering masks
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;

  // Hand-over of a twisted table word to the output stage
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] word;
  } mtw_load_t;

endpackage

`default_nettype wire

@@ hw/rtl/mt19937_word_generator.sv @@
// Top level of the MT19937 word generator: sequencer, seed register and table.
`default_nettype none

// MT19937 32-bit word generator. Each input beat on the in_ channel requests
// one tempered 32-bit word, which appears as one beat on the out_ channel.
// The 624-word state table sits in a single RAM with one read port, and the
// twist is applied to one table word per request, so a normal request runs from
// the accept cycle through three serial reads of that port (current word, next
// word, word 397 ahead) to the update and write-back, which waits for a free
// output register. A request with the reseed flag set, and the first request
// after reset, first fills all 624 entries of the table from the seed register
// at one entry per cycle. The seed is written through cfg_we and cfg_wdata,
// resets to 5489 and takes effect at the next seeding. A finished word waits
// in the output register while the next request is already being accepted.

module mt19937_word_generator
  import mtw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [WORD_W-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,    // [0] reseed, [7:1] zero
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [WORD_W-1:0] out_tdata    // [31:0] random_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CALC
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] OFFSET    = IDX_W'(TWIST_OFFSET);
  localparam logic [IDX_W-1:0] WRAP_FROM = IDX_W'(TABLE_DEPTH - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] WRAP_BACK = IDX_W'(TABLE_DEPTH - TWIST_OFFSET);

  state_t            state_r;
  logic              seeded_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  fill_cnt_r;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] prev_r;
  logic [WORD_W-1:0] cur_r;
  logic [WORD_W-1:0] next_r;

  logic              in_accept;
  logic              out_free;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W-1:0]  idx_far;
  logic [WORD_W-1:0] fill_val;
  logic [WORD_W-1:0] twist_val;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  mtw_load_t         load;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Neighbouring and far indexes of the word being twisted.
  assign idx_next = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign idx_far  = (idx_r < WRAP_FROM) ? idx_r + OFFSET : idx_r - WRAP_BACK;

  // Seeding recurrence: entry zero is the seed itself.
  always_comb begin
    if (fill_cnt_r == '0) begin
      fill_val = seed_r;
    end else begin
      fill_val = WORD_W'(INIT_MULT * (prev_r ^ (prev_r >> 30)))
               + WORD_W'(fill_cnt_r);
    end
  end

  // Twist of one entry; the far word arrives from the RAM in S_CALC.
  always_comb begin
    logic [WORD_W-1:0] y;
    y         = (cur_r & HIGH_BIT_MASK) | (next_r & LOW_BITS_MASK);
    twist_val = ram_rdata ^ (y >> 1);
    if (y[0]) begin
      twist_val = twist_val ^ TWIST_MATRIX;
    end
  end

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = twist_val;
    ram_raddr = idx_r;
    case (state_r)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_cnt_r;
        ram_wdata = fill_val;
      end
      S_RD1: begin
        ram_raddr = idx_next;
      end
      S_RD2: begin
        ram_raddr = idx_far;
      end
      S_CALC: begin
        ram_raddr = idx_far;
        ram_we    = out_free;
      end
      default: begin
        ram_raddr = idx_r;
      end
    endcase
  end

  assign load.load = (state_r == S_CALC) && out_free;
  assign load.word = twist_val;

  // Seed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_AT_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seeded_r   <= 1'b0;
      idx_r      <= '0;
      fill_cnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (in_tdata[0] || !seeded_r) begin
              state_r    <= S_FILL;
              fill_cnt_r <= '0;
            end else begin
              state_r <= S_RD0;
            end
          end
        end
        S_FILL: begin
          if (fill_cnt_r == LAST_IDX) begin
            state_r  <= S_RD0;
            seeded_r <= 1'b1;
            idx_r    <= '0;
          end else begin
            fill_cnt_r <= fill_cnt_r + 1'b1;
          end
        end
        S_RD0: begin
          state_r <= S_RD1;
        end
        S_RD1: begin
          state_r <= S_RD2;
        end
        S_RD2: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (out_free) begin
            state_r <= S_IDLE;
            idx_r   <= idx_next;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: previous seeded word and the two near table words.
  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      prev_r <= fill_val;
    end
    if (state_r == S_RD1) begin
      cur_r <= ram_rdata;
    end
    if (state_r == S_RD2) begin
      next_r <= ram_rdata;
    end
  end

  mtw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtw_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // An accepted request always starts work on the table.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_FILL || state_r == S_RD0))
    else $error("accepted request did not start a fill or a read");

  // A finished fill hands over to the first read at index zero.
  a_fill_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && fill_cnt_r == LAST_IDX) |=>
      (state_r == S_RD0 && idx_r == '0 && seeded_r))
    else $error("fill did not end at index zero");

  // A word is only loaded into an output register that can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load.load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

  // The table index never leaves the table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r <= LAST_IDX) && (fill_cnt_r <= LAST_IDX))
    else $error("table index out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mtw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mtw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/mtw_out_stage.sv @@
// Tempering and output register of the MT19937 word generator.
`default_nettype none

module mtw_out_stage
  import mtw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtw_load_t         load_i,
  output logic                   free_o,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [WORD_W-1:0] out_tdata   // [31:0] random_word
);

  logic              valid_r;
  logic              valid_nxt;
  logic [WORD_W-1:0] data_r;

  // Standard MT19937 tempering of one table word.
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // The register may take a new beat when empty or being drained.
  assign free_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (load_i.load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (load_i.load) begin
      data_r <= temper(load_i.word);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

@@ verif/mt19937_word_generator_checker.sv @@
// Checker for the MT19937 word generator: predicts every word and compares the out_ beats.
`timescale 1ns / 100ps

module mt19937_word_generator_checker
  import mtw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,      // [0] reseed, [7:1] zero
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [WORD_W-1:0] out_tdata,     // [31:0] random_word
  output int                fail_count,
  output int                words_pending
);

  // An index above TABLE_DEPTH means that no seeding has happened since reset.
  localparam int UNSEEDED_PTR = TABLE_DEPTH + 1;

  logic [WORD_W-1:0] state_words [TABLE_DEPTH];
  int                word_ptr;
  logic [WORD_W-1:0] seed_value;
  logic [WORD_W-1:0] expected_words [$];
  logic [WORD_W-1:0] oldest_word;

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  // Fill the table from a seed with the usual initialisation recurrence.
  function automatic void fill_from_seed(input logic [WORD_W-1:0] start_value);
    state_words[0] = start_value;
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      state_words[i] = INIT_MULT * (state_words[i-1] ^ (state_words[i-1] >> 30))
                       + WORD_W'(i);
    end
    word_ptr = TABLE_DEPTH;
  endfunction

  // Twist the whole table in place, lowest entry first.
  function automatic void twist_table();
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] updated;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      mixed   = (state_words[k] & HIGH_BIT_MASK)
                | (state_words[(k + 1) % TABLE_DEPTH] & LOW_BITS_MASK);
      updated = state_words[(k + TWIST_OFFSET) % TABLE_DEPTH] ^ (mixed >> 1);
      if (mixed[0]) begin
        updated = updated ^ TWIST_MATRIX;
      end
      state_words[k] = updated;
    end
    word_ptr = 0;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Advance the generator by one request and give the tempered word.
  function automatic logic [WORD_W-1:0] next_word(input logic reseed);
    logic [WORD_W-1:0] raw;
    if (reseed || word_ptr >= UNSEEDED_PTR) begin
      fill_from_seed(seed_value);
    end
    if (word_ptr >= TABLE_DEPTH) begin
      twist_table();
    end
    raw = state_words[word_ptr];
    word_ptr++;
    return temper(raw);
  endfunction

  // Track the seed register, check each result beat and predict each request beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      word_ptr   = UNSEEDED_PTR;
      seed_value = SEED_AT_RESET;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        seed_value = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: random_word expected none, actual %08h", $time, out_tdata);
        end else begin
          oldest_word = expected_words.pop_front();
          if (out_tdata !== oldest_word) begin
            fail_count++;
            $display("%0t: random_word expected %08h, actual %08h",
                     $time, oldest_word, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_words.push_back(next_word(in_tdata[0]));
      end
    end
    words_pending = expected_words.size();
  end

endmodule

@@ verif/mt19937_word_generator_tb.sv @@
// Testbench top of the MT19937 word generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module mt19937_word_generator_tb;
  import mtw_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int LONG_RUN     = 260;
  localparam int PHASE_WORDS  = 40;
  localparam int PHASES       = 4;
  localparam int RESEED_PCT   = 4;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [WORD_W-1:0] cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;      // [0] reseed, [7:1] zero
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [WORD_W-1:0] out_tdata;            // [31:0] random_word

  int fail_count;
  int words_pending;
  int cycle_count  = 0;
  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;

  mt19937_word_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mt19937_word_generator_checker word_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** mt19937_word_generator: FAILED **");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one request beat, sometimes after an idle burst, and wait until it is taken.
  task automatic send_word(input logic reseed);
    int gap;
    gap = (!no_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, reseed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic wait_all_words();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [WORD_W-1:0] next_seed;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // The first request after reset seeds from the reset value without the flag.
    repeat (4) send_word(1'b0);
    // Reseeding restarts the sequence; two in a row as well.
    send_word(1'b1);
    send_word(1'b1);
    repeat (2) send_word(1'b0);
    wait_all_words();

    // A new seed is not used until the next reseed.
    write_seed('0);
    send_word(1'b0);
    send_word(1'b1);
    repeat (2) send_word(1'b0);
    wait_all_words();
    write_seed('1);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    wait_all_words();
    write_seed(32'd1);
    send_word(1'b1);
    send_word(1'b0);
    wait_all_words();

    // A long run without reseeding, far enough that the far index wraps to the table start.
    write_seed($urandom);
    send_word(1'b1);
    repeat (LONG_RUN) send_word(1'b0);

    // Hold the result side off while requests keep coming, then pause to drain.
    hold_off_req = 1'b1;
    repeat (16) send_word(1'b0);
    wait_all_words();

    // Random phases, each with a fresh seed; the last one without idling.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       next_seed = '0;
        1:       next_seed = '1;
        default: next_seed = $urandom;
      endcase
      write_seed(next_seed);
      if (p == PHASES - 1) begin
        no_idle = 1'b1;
      end
      repeat (PHASE_WORDS) send_word($urandom_range(0, 99) < RESEED_PCT);
      wait_all_words();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("** mt19937_word_generator: PASSED **");
    end else begin
      $display("** mt19937_word_generator: FAILED **");
    end
    $finish;
  end

endmodule
